>>> hdl/mcbq_pkg.sv
package mcbq_pkg;

    // Fixed widths of the datapath
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int STATE_W  = 64;   // Q40.24 intermediate
    localparam int TSUM_W   = 68;   // w + 2*d1 + d2
    localparam int MUL_W    = 33;   // shared signed multiplier operand width
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 100;  // holds both sums exactly
    localparam int COEF_SETS = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_B0_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A1_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A2_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B0_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A1_1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A2_1   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd6;

    // Output saturation limits
    localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

    // Microprogram addresses
    localparam int PC_BITS = 4;
    typedef logic [PC_BITS-1:0] t_pc;
    localparam t_pc PC_IDLE    = 4'd0;
    localparam t_pc PC_FB_D1LO = 4'd1;
    localparam t_pc PC_FB_D1HI = 4'd2;
    localparam t_pc PC_FB_D2LO = 4'd3;
    localparam t_pc PC_FB_D2HI = 4'd4;
    localparam t_pc PC_FB_LAST = 4'd5;
    localparam t_pc PC_WSTEP   = 4'd6;
    localparam t_pc PC_TSTEP   = 4'd7;
    localparam t_pc PC_FF_LO   = 4'd8;
    localparam t_pc PC_FF_MID  = 4'd9;
    localparam t_pc PC_FF_HI   = 4'd10;
    localparam t_pc PC_FF_LAST = 4'd11;
    localparam t_pc PC_OUT     = 4'd12;

    // Multiplier operand A source
    typedef enum logic [2:0] {
        A_D1LO, A_D1HI, A_D2LO, A_D2HI, A_TLO, A_TMID, A_THI
    } t_asel;

    // Multiplier operand B source
    typedef enum logic [1:0] {
        B_A1, B_A2, B_B0
    } t_bsel;

    // Accumulator operation
    typedef enum logic [2:0] {
        ACC_HOLD, ACC_INIT_FB, ACC_INIT_FF, ACC_ADD, ACC_SUB
    } t_accop;

    // Weight of the registered product
    typedef enum logic [1:0] {
        SH_0, SH_32, SH_64
    } t_shift;

    // Sequencing of the step counter
    typedef enum logic [1:0] {
        J_NEXT,   // go to next step
        J_IN,     // wait for input; bypass items jump to target
        J_OUT,    // wait for free output register, then jump to target
        J_GOTO    // unconditional jump to target
    } t_jump;

    // One control word
    typedef struct packed {
        t_asel  asel;
        t_bsel  bsel;
        t_accop accop;
        t_shift shift;
        logic   ld_w;
        logic   ld_t;
        logic   upd_state;
        logic   ld_out;
        t_jump  jump;
        t_pc    target;
    } t_uword;

    // Status the sequencer branches on
    typedef struct packed {
        logic in_valid;
        logic bypass;
        logic out_free;
    } t_seq_stat;

    localparam t_uword UW_NOP = '{
        asel: A_D1LO, bsel: B_A1, accop: ACC_HOLD, shift: SH_0,
        ld_w: 1'b0, ld_t: 1'b0, upd_state: 1'b0, ld_out: 1'b0,
        jump: J_NEXT, target: PC_IDLE
    };

    // Microprogram ROM
    function automatic t_uword ucode(input t_pc pc);
        t_uword uw;
        uw = UW_NOP;
        unique case (pc)
            PC_IDLE: begin
                uw.jump   = J_IN;
                uw.target = PC_OUT;
            end
            // feedback sum: x*2^54 + 2^29 - a1*d1 - a2*d2
            PC_FB_D1LO: begin
                uw.accop = ACC_INIT_FB;
                uw.asel  = A_D1LO;
                uw.bsel  = B_A1;
            end
            PC_FB_D1HI: begin
                uw.asel  = A_D1HI;
                uw.bsel  = B_A1;
                uw.accop = ACC_SUB;
                uw.shift = SH_0;
            end
            PC_FB_D2LO: begin
                uw.asel  = A_D2LO;
                uw.bsel  = B_A2;
                uw.accop = ACC_SUB;
                uw.shift = SH_32;
            end
            PC_FB_D2HI: begin
                uw.asel  = A_D2HI;
                uw.bsel  = B_A2;
                uw.accop = ACC_SUB;
                uw.shift = SH_0;
            end
            PC_FB_LAST: begin
                uw.accop = ACC_SUB;
                uw.shift = SH_32;
            end
            PC_WSTEP: begin
                uw.ld_w = 1'b1;
            end
            PC_TSTEP: begin
                uw.ld_t  = 1'b1;
                uw.accop = ACC_INIT_FF;
            end
            // feed-forward product: b0*t + 2^55
            PC_FF_LO: begin
                uw.asel = A_TLO;
                uw.bsel = B_B0;
            end
            PC_FF_MID: begin
                uw.asel  = A_TMID;
                uw.bsel  = B_B0;
                uw.accop = ACC_ADD;
                uw.shift = SH_0;
            end
            PC_FF_HI: begin
                uw.asel  = A_THI;
                uw.bsel  = B_B0;
                uw.accop = ACC_ADD;
                uw.shift = SH_32;
            end
            PC_FF_LAST: begin
                uw.accop     = ACC_ADD;
                uw.shift     = SH_64;
                uw.upd_state = 1'b1;
            end
            PC_OUT: begin
                uw.ld_out = 1'b1;
                uw.jump   = J_OUT;
                uw.target = PC_IDLE;
            end
            default: begin
                uw.jump   = J_GOTO;
                uw.target = PC_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

>>> hdl/mcbq_seq.sv
module mcbq_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcbq_pkg::t_seq_stat i_stat,
    output mcbq_pkg::t_uword    o_uword
);

    mcbq_pkg::t_pc r_pc;
    mcbq_pkg::t_pc n_pc;

    // control word of the current step
    assign o_uword = mcbq_pkg::ucode(r_pc);

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mcbq_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // next step and conditional jumps
    always_comb begin
        n_pc = r_pc;
        unique case (o_uword.jump)
            mcbq_pkg::J_NEXT: begin
                n_pc = mcbq_pkg::t_pc'(r_pc + 1'b1);
            end
            mcbq_pkg::J_IN: begin
                if (i_stat.in_valid) begin
                    n_pc = i_stat.bypass ? o_uword.target
                                         : mcbq_pkg::t_pc'(r_pc + 1'b1);
                end
            end
            mcbq_pkg::J_OUT: begin
                if (i_stat.out_free) begin
                    n_pc = o_uword.target;
                end
            end
            mcbq_pkg::J_GOTO: begin
                n_pc = o_uword.target;
            end
            default: begin
                n_pc = mcbq_pkg::PC_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/mcbq_dp.sv
module mcbq_dp #(
    parameter int CHANNELS = 2
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  mcbq_pkg::t_uword                                       i_ctrl,
    input  logic                                                   i_in_fire,
    input  logic                                                   i_channel,
    input  logic signed [mcbq_pkg::SAMPLE_W-1:0]                   i_sample,
    input  logic                                                   i_bypass,
    input  logic [mcbq_pkg::COEF_SETS-1:0][mcbq_pkg::COEF_W-1:0]   i_b0,
    input  logic [mcbq_pkg::COEF_SETS-1:0][mcbq_pkg::COEF_W-1:0]   i_a1,
    input  logic [mcbq_pkg::COEF_SETS-1:0][mcbq_pkg::COEF_W-1:0]   i_a2,
    output logic                                                   o_channel,
    output logic signed [mcbq_pkg::SAMPLE_W-1:0]                   o_result
);

    localparam int ACC_W = mcbq_pkg::ACC_W;

    // item registers
    logic                                   r_ch;
    logic signed [mcbq_pkg::SAMPLE_W-1:0]   r_x;
    logic                                   r_byp;

    // delay line per channel
    logic [mcbq_pkg::STATE_W-1:0] r_d1 [CHANNELS];
    logic [mcbq_pkg::STATE_W-1:0] r_d2 [CHANNELS];

    // working registers
    logic signed [mcbq_pkg::PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [ACC_W-1:0]             n_acc;
    logic [mcbq_pkg::STATE_W-1:0]        r_w;
    logic [mcbq_pkg::TSUM_W-1:0]         r_t;

    logic [mcbq_pkg::STATE_W-1:0]        w_d1;
    logic [mcbq_pkg::STATE_W-1:0]        w_d2;
    logic [mcbq_pkg::COEF_W-1:0]         w_b0;
    logic [mcbq_pkg::COEF_W-1:0]         w_a1;
    logic [mcbq_pkg::COEF_W-1:0]         w_a2;
    logic signed [mcbq_pkg::MUL_W-1:0]   w_a_op;
    logic signed [mcbq_pkg::MUL_W-1:0]   w_b_op;
    logic signed [ACC_W-1:0]             w_prod_ext;
    logic signed [ACC_W-1:0]             w_prod_sh;
    logic [ACC_W-1:0]                    w_fb_init;
    logic [ACC_W-1:0]                    w_ff_init;
    logic [mcbq_pkg::STATE_W-1:0]        w_x_q24;
    logic                                w_w_fits;
    logic [mcbq_pkg::STATE_W-1:0]        w_w_new;
    logic [mcbq_pkg::TSUM_W-1:0]         w_t_new;
    logic [ACC_W-57:0]                   w_q;
    logic                                w_y_fits;
    logic [mcbq_pkg::SAMPLE_W-1:0]       w_y_sat;

    assign w_d1 = r_d1[r_ch];
    assign w_d2 = r_d2[r_ch];
    assign w_b0 = i_b0[r_ch];
    assign w_a1 = i_a1[r_ch];
    assign w_a2 = i_a2[r_ch];

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_ch  <= i_channel;
            r_x   <= i_sample;
            r_byp <= i_bypass;
        end
    end

    // multiplier operand A: 32-bit chunks (the top chunk of t is 4 bits), upper chunk signed
    always_comb begin
        unique case (i_ctrl.asel)
            mcbq_pkg::A_D1LO: w_a_op = $signed({1'b0, w_d1[31:0]});
            mcbq_pkg::A_D1HI: w_a_op = $signed({w_d1[63], w_d1[63:32]});
            mcbq_pkg::A_D2LO: w_a_op = $signed({1'b0, w_d2[31:0]});
            mcbq_pkg::A_D2HI: w_a_op = $signed({w_d2[63], w_d2[63:32]});
            mcbq_pkg::A_TLO:  w_a_op = $signed({1'b0, r_t[31:0]});
            mcbq_pkg::A_TMID: w_a_op = $signed({1'b0, r_t[63:32]});
            mcbq_pkg::A_THI:  w_a_op = $signed({{29{r_t[67]}}, r_t[67:64]});
            default:          w_a_op = '0;
        endcase
    end

    // multiplier operand B: coefficient
    always_comb begin
        unique case (i_ctrl.bsel)
            mcbq_pkg::B_A1: w_b_op = $signed({w_a1[31], w_a1});
            mcbq_pkg::B_A2: w_b_op = $signed({w_a2[31], w_a2});
            mcbq_pkg::B_B0: w_b_op = $signed({1'b0, w_b0});
            default:        w_b_op = '0;
        endcase
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= w_a_op * w_b_op;
    end

    // product weighted by its chunk position (modular, final sum fits)
    assign w_prod_ext = $signed({{(ACC_W - mcbq_pkg::PROD_W){r_prod[mcbq_pkg::PROD_W-1]}},
                                 r_prod});
    always_comb begin
        unique case (i_ctrl.shift)
            mcbq_pkg::SH_0:  w_prod_sh = w_prod_ext;
            mcbq_pkg::SH_32: w_prod_sh = w_prod_ext <<< 32;
            mcbq_pkg::SH_64: w_prod_sh = w_prod_ext <<< 64;
            default:         w_prod_sh = w_prod_ext;
        endcase
    end

    // x*2^54 + 2^29 and 2^55 need no adder: the bits do not overlap
    assign w_fb_init = {{(ACC_W - 70){r_x[15]}}, r_x, 24'b0, 1'b1, 29'b0};
    assign w_ff_init = {{(ACC_W - 56){1'b0}}, 1'b1, 55'b0};

    // accumulator
    always_comb begin
        unique case (i_ctrl.accop)
            mcbq_pkg::ACC_HOLD:    n_acc = r_acc;
            mcbq_pkg::ACC_INIT_FB: n_acc = $signed(w_fb_init);
            mcbq_pkg::ACC_INIT_FF: n_acc = $signed(w_ff_init);
            mcbq_pkg::ACC_ADD:     n_acc = r_acc + w_prod_sh;
            mcbq_pkg::ACC_SUB:     n_acc = r_acc - w_prod_sh;
            default:               n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // w = sum >>> 30; on overflow of 64 bits it falls back to the sample
    assign w_x_q24  = {{24{r_x[15]}}, r_x, 24'b0};
    assign w_w_fits = (&r_acc[ACC_W-1:93]) | ~(|r_acc[ACC_W-1:93]);
    assign w_w_new  = w_w_fits ? r_acc[93:30] : w_x_q24;

    // t = w + 2*d1 + d2
    assign w_t_new = {{4{r_w[63]}}, r_w}
                   + {{3{w_d1[63]}}, w_d1, 1'b0}
                   + {{4{w_d2[63]}}, w_d2};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_w) begin
            r_w <= w_w_new;
        end
        if (i_ctrl.ld_t) begin
            r_t <= w_t_new;
        end
    end

    // delay line shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_d1[c] <= '0;
                r_d2[c] <= '0;
            end
        end else if (i_ctrl.upd_state) begin
            r_d2[r_ch] <= w_d1;
            r_d1[r_ch] <= r_w;
        end
    end

    // output: sum >>> 56, saturated to 16 bits
    assign w_q      = r_acc[ACC_W-1:56];
    assign w_y_fits = (&w_q[ACC_W-57:15]) | ~(|w_q[ACC_W-57:15]);
    assign w_y_sat  = w_y_fits ? w_q[15:0]
                    : (w_q[ACC_W-57] ? mcbq_pkg::SAT_MIN : mcbq_pkg::SAT_MAX);

    assign o_channel = r_ch;
    assign o_result  = r_byp ? r_x : $signed(w_y_sat);

endmodule

>>> hdl/multichannel_biquad_lowpass.sv
// Filtered item: feedback sum, w, t and feed-forward sum in turn, then the
// result is loaded once the result register is free; the next input is taken
// only after that load. Bypassed item: straight to the output step. The one
// shared 33x33 multiplier does seven partial products per filtered item.
// Reset (i_rst_n low, synchronous): coefficients, enable mask and both delay
// stages of every channel clear to zero; the result register empties.
module multichannel_biquad_lowpass #(
    parameter int CHANNELS = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_wr_en,
    input  logic [mcbq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mcbq_pkg::COEF_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_channel,
    input  logic signed [mcbq_pkg::SAMPLE_W-1:0]  i_sample_in,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_channel_out,
    output logic signed [mcbq_pkg::SAMPLE_W-1:0]  o_filtered
);

    logic [mcbq_pkg::COEF_SETS-1:0][mcbq_pkg::COEF_W-1:0] r_b0;
    logic [mcbq_pkg::COEF_SETS-1:0][mcbq_pkg::COEF_W-1:0] r_a1;
    logic [mcbq_pkg::COEF_SETS-1:0][mcbq_pkg::COEF_W-1:0] r_a2;
    logic [1:0]                                           r_enable;

    logic                                 r_out_valid;
    logic                                 r_out_ch;
    logic [mcbq_pkg::SAMPLE_W-1:0]        r_out_y;

    mcbq_pkg::t_uword                     w_uword;
    mcbq_pkg::t_seq_stat                  w_stat;
    logic                                 w_in_fire;
    logic                                 w_bypass;
    logic                                 w_out_free;
    logic                                 w_out_load;
    logic                                 w_dp_ch;
    logic signed [mcbq_pkg::SAMPLE_W-1:0] w_dp_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_enable <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mcbq_pkg::CFG_B0_0:   r_b0[0]  <= i_cfg_data;
                mcbq_pkg::CFG_A1_0:   r_a1[0]  <= i_cfg_data;
                mcbq_pkg::CFG_A2_0:   r_a2[0]  <= i_cfg_data;
                mcbq_pkg::CFG_B0_1:   r_b0[1]  <= i_cfg_data;
                mcbq_pkg::CFG_A1_1:   r_a1[1]  <= i_cfg_data;
                mcbq_pkg::CFG_A2_1:   r_a2[1]  <= i_cfg_data;
                mcbq_pkg::CFG_ENABLE: r_enable <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // input side; nothing is taken while in reset
    assign o_ready   = i_rst_n && (w_uword.jump == mcbq_pkg::J_IN);
    assign w_in_fire = i_valid && o_ready;
    assign w_bypass  = (32'(i_channel) >= CHANNELS) || !r_enable[i_channel];

    // output register frees on transfer
    assign w_out_free = !r_out_valid || i_ready;
    assign w_out_load = w_uword.ld_out && w_out_free;

    assign w_stat.in_valid = i_valid;
    assign w_stat.bypass   = w_bypass;
    assign w_stat.out_free = w_out_free;

    mcbq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uword (w_uword)
    );

    mcbq_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_uword),
        .i_in_fire (w_in_fire),
        .i_channel (i_channel),
        .i_sample  (i_sample_in),
        .i_bypass  (w_bypass),
        .i_b0      (r_b0),
        .i_a1      (r_a1),
        .i_a2      (r_a2),
        .o_channel (w_dp_ch),
        .o_result  (w_dp_y)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ch <= w_dp_ch;
            r_out_y  <= w_dp_y;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_filtered    = $signed(r_out_y);

    // an accepted item keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_ready)
        else $error("input accepted back to back");

    // a new result only appears from the output step
    a_result_from_out_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_uword.ld_out))
        else $error("result loaded outside the output step");

    // the output step is never left with the result register still blocked
    a_out_step_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uword.ld_out && !w_out_free) |=> w_uword.ld_out)
        else $error("output step left while result register full");

endmodule
